// File: hdl/ttd_pkg.sv
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types and constants for the touch tap detector: payload structs,
// configuration register layout and reset values.
// ----------------------------------------------------------------------------
package ttd_pkg;

   localparam int COORD_BITS = 12;
   localparam int TIME_BITS  = 32;
   localparam int DUR_BITS   = 16;
   localparam int MOVE_BITS  = 12;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [DUR_BITS-1:0]  TAP_MAX_TIME_RST  = 16'd300;
   localparam logic [MOVE_BITS-1:0] MOVE_LIMIT_RST    = 12'd10;
   localparam logic [DUR_BITS-1:0]  TAP_GAP_MIN_RST   = 16'd150;
   localparam logic [DUR_BITS-1:0]  BOUNCE_WINDOW_RST = 16'd40;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_TAP_MAX_TIME  = 2'd0,
      REG_MOVE_LIMIT    = 2'd1,
      REG_TAP_GAP_MIN   = 2'd2,
      REG_BOUNCE_WINDOW = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  pressed;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [TIME_BITS-1:0]  now_time;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] tap_x;
      logic [COORD_BITS-1:0] tap_y;
   } rsp_type;

   typedef struct packed {
      logic [DUR_BITS-1:0]  tap_max_time;
      logic [MOVE_BITS-1:0] move_limit;
      logic [DUR_BITS-1:0]  tap_gap_min;
      logic [DUR_BITS-1:0]  bounce_window;
   } cfg_type;

endpackage

// File: hdl/ttd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ttd_cfg_regs
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module ttd_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ttd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ttd_pkg::CSR_DATA_BITS-1:0]   csr_wr_data,
   output ttd_pkg::cfg_type                    cfg
);

   ttd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ttd_pkg::REG_TAP_MAX_TIME: begin
               cfg_in.tap_max_time = csr_wr_data[ttd_pkg::DUR_BITS-1:0];
            end
            ttd_pkg::REG_MOVE_LIMIT: begin
               cfg_in.move_limit = csr_wr_data[ttd_pkg::MOVE_BITS-1:0];
            end
            ttd_pkg::REG_TAP_GAP_MIN: begin
               cfg_in.tap_gap_min = csr_wr_data[ttd_pkg::DUR_BITS-1:0];
            end
            ttd_pkg::REG_BOUNCE_WINDOW: begin
               cfg_in.bounce_window = csr_wr_data[ttd_pkg::DUR_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_max_time  <= ttd_pkg::TAP_MAX_TIME_RST;
         cfg_ff.move_limit    <= ttd_pkg::MOVE_LIMIT_RST;
         cfg_ff.tap_gap_min   <= ttd_pkg::TAP_GAP_MIN_RST;
         cfg_ff.bounce_window <= ttd_pkg::BOUNCE_WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/ttd_in_reg.sv
// ----------------------------------------------------------------------------
// ttd_in_reg
// Input register: captures one poll sample and holds it until the tap
// logic takes it.
// ----------------------------------------------------------------------------
module ttd_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ttd_pkg::req_type req_data,
   output logic             smp_valid,
   input  logic             smp_take,
   output ttd_pkg::req_type smp_data
);

   logic             valid_ff, valid_in;
   ttd_pkg::req_type data_ff, data_in;
   logic             accept;

   // register frees up in the same cycle the tap logic takes its sample
   assign req_stall = valid_ff && !smp_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (smp_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign smp_valid = valid_ff;
   assign smp_data  = data_ff;

endmodule

// File: hdl/ttd_tap_logic.sv
// ----------------------------------------------------------------------------
// ttd_tap_logic
// Touch state, tap decision and the result register. One sample is
// processed per cycle whenever the result register can take a new value.
// ----------------------------------------------------------------------------
module ttd_tap_logic (
   input  logic             clock,
   input  logic             reset,
   input  ttd_pkg::cfg_type cfg,
   input  logic             smp_valid,
   output logic             smp_take,
   input  ttd_pkg::req_type smp_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ttd_pkg::rsp_type rsp_data
);

   localparam int CB = ttd_pkg::COORD_BITS;
   localparam int TB = ttd_pkg::TIME_BITS;

   logic          finger_down_ff, finger_down_in;
   logic          has_moved_ff, has_moved_in;
   logic [CB-1:0] start_x_ff, start_x_in;
   logic [CB-1:0] start_y_ff, start_y_in;
   logic [TB-1:0] press_time_ff, press_time_in;
   logic [TB-1:0] lift_time_ff, lift_time_in;
   logic [TB-1:0] prev_tap_time_ff, prev_tap_time_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ttd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [TB-1:0] since_lift, held, since_tap;
   logic [CB-1:0] dx, dy;
   logic          bounce, dragged, tap_ok, emit;

   assign smp_take = smp_valid && (!rsp_valid_ff || !rsp_stall);

   // wrapping time differences
   assign since_lift = smp_data.now_time - lift_time_ff;
   assign held       = smp_data.now_time - press_time_ff;
   assign since_tap  = smp_data.now_time - prev_tap_time_ff;

   assign dx = (smp_data.pos_x >= start_x_ff) ? (smp_data.pos_x - start_x_ff)
                                              : (start_x_ff - smp_data.pos_x);
   assign dy = (smp_data.pos_y >= start_y_ff) ? (smp_data.pos_y - start_y_ff)
                                              : (start_y_ff - smp_data.pos_y);

   assign bounce  = since_lift < {{(TB-ttd_pkg::DUR_BITS){1'b0}}, cfg.bounce_window};
   assign dragged = (dx >= cfg.move_limit) || (dy >= cfg.move_limit);
   assign tap_ok  = !has_moved_ff
                    && (held <= {{(TB-ttd_pkg::DUR_BITS){1'b0}}, cfg.tap_max_time})
                    && (since_tap >= {{(TB-ttd_pkg::DUR_BITS){1'b0}}, cfg.tap_gap_min});
   assign emit    = !smp_data.pressed && finger_down_ff && tap_ok;

   always_comb begin
      finger_down_in   = finger_down_ff;
      has_moved_in     = has_moved_ff;
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      press_time_in    = press_time_ff;
      lift_time_in     = lift_time_ff;
      prev_tap_time_in = prev_tap_time_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      if (smp_take) begin
         rsp_valid_in      = emit;
         rsp_data_in.tap_x = start_x_ff;
         rsp_data_in.tap_y = start_y_ff;
         if (smp_data.pressed && !finger_down_ff) begin
            // press edge; bounced presses leave everything alone
            if (!bounce) begin
               finger_down_in = 1'b1;
               has_moved_in   = 1'b0;
               start_x_in     = smp_data.pos_x;
               start_y_in     = smp_data.pos_y;
               press_time_in  = smp_data.now_time;
            end
         end else if (smp_data.pressed) begin
            if (dragged) begin
               has_moved_in = 1'b1;
            end
         end else if (finger_down_ff) begin
            finger_down_in = 1'b0;
            lift_time_in   = smp_data.now_time;
            if (tap_ok) begin
               prev_tap_time_in = smp_data.now_time;
            end
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finger_down_ff   <= 1'b0;
         has_moved_ff     <= 1'b0;
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         press_time_ff    <= '0;
         lift_time_ff     <= '0;
         prev_tap_time_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         finger_down_ff   <= finger_down_in;
         has_moved_ff     <= has_moved_in;
         start_x_ff       <= start_x_in;
         start_y_ff       <= start_y_in;
         press_time_ff    <= press_time_in;
         lift_time_ff     <= lift_time_in;
         prev_tap_time_ff <= prev_tap_time_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hdl/touch_tap_detector.sv
// a tap is loaded into the result register when the tap logic takes its release sample from the input register
// throughput: one sample per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken
// reset: synchronous; clears touch state and times to zero, loads register defaults
// ----------------------------------------------------------------------------
// touch_tap_detector
// Tap recognizer for a polled touch panel: debounces presses, flags drags and
// reports the press point of each accepted tap.
// ----------------------------------------------------------------------------
module touch_tap_detector (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ttd_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ttd_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [ttd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ttd_pkg::CSR_DATA_BITS-1:0] csr_wr_data
);

   ttd_pkg::cfg_type cfg;
   ttd_pkg::req_type smp_data;
   logic             smp_valid;
   logic             smp_take;

   ttd_cfg_regs u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ttd_in_reg u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .smp_valid (smp_valid),
      .smp_take  (smp_take),
      .smp_data  (smp_data)
   );

   ttd_tap_logic u_tap (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .smp_valid (smp_valid),
      .smp_take  (smp_take),
      .smp_data  (smp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/ttd_checker.sv
// ----------------------------------------------------------------------------
// ttd_checker
// Port-level checks for the touch tap detector, bound to the top level.
// ----------------------------------------------------------------------------
module ttd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ttd_pkg::rsp_type rsp_data
);

   // no result transaction right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input side never backs up while the result side is empty or draining
   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while result side free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

endmodule

bind touch_tap_detector ttd_checker u_ttd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_data    (rsp_data)
);

// File: tb/touch_tap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_checker
// Watches the sample, tap and register ports of the touch tap detector, keeps
// its own copy of the touch state and settings, predicts every tap and
// compares each tap transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module touch_tap_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  ttd_pkg::req_type                  req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  ttd_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [ttd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ttd_pkg::CSR_DATA_BITS-1:0] csr_wr_data,
   output int                                error_count,
   output int                                taps_pending
);

   ttd_pkg::cfg_type                settings;
   logic                            finger_down;
   logic                            has_moved;
   logic [ttd_pkg::COORD_BITS-1:0]  start_x;
   logic [ttd_pkg::COORD_BITS-1:0]  start_y;
   logic [ttd_pkg::TIME_BITS-1:0]   press_time;
   logic [ttd_pkg::TIME_BITS-1:0]   lift_time;
   logic [ttd_pkg::TIME_BITS-1:0]   prev_tap_time;
   ttd_pkg::rsp_type                expected_taps[$];
   ttd_pkg::rsp_type                want_tap;

   function automatic logic [ttd_pkg::COORD_BITS-1:0] travel(
      input logic [ttd_pkg::COORD_BITS-1:0] a,
      input logic [ttd_pkg::COORD_BITS-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic track_touch(input ttd_pkg::req_type s);
      logic [ttd_pkg::TIME_BITS-1:0] since_lift;
      logic [ttd_pkg::TIME_BITS-1:0] held;
      logic [ttd_pkg::TIME_BITS-1:0] since_tap;
      since_lift = s.now_time - lift_time;
      held       = s.now_time - press_time;
      since_tap  = s.now_time - prev_tap_time;
      if (s.pressed && !finger_down) begin
         // a press inside the bounce window leaves everything untouched
         if (since_lift >= settings.bounce_window) begin
            finger_down = 1'b1;
            has_moved   = 1'b0;
            start_x     = s.pos_x;
            start_y     = s.pos_y;
            press_time  = s.now_time;
         end
      end else if (s.pressed) begin
         if (travel(s.pos_x, start_x) >= settings.move_limit ||
             travel(s.pos_y, start_y) >= settings.move_limit)
            has_moved = 1'b1;
      end else if (finger_down) begin
         finger_down = 1'b0;
         lift_time   = s.now_time;
         if (!has_moved && held <= settings.tap_max_time &&
             since_tap >= settings.tap_gap_min) begin
            prev_tap_time = s.now_time;
            expected_taps.push_back('{tap_x: start_x, tap_y: start_y});
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings      = '{tap_max_time: ttd_pkg::TAP_MAX_TIME_RST,
                           move_limit: ttd_pkg::MOVE_LIMIT_RST,
                           tap_gap_min: ttd_pkg::TAP_GAP_MIN_RST,
                           bounce_window: ttd_pkg::BOUNCE_WINDOW_RST};
         finger_down   = 1'b0;
         has_moved     = 1'b0;
         start_x       = '0;
         start_y       = '0;
         press_time    = '0;
         lift_time     = '0;
         prev_tap_time = '0;
         error_count   = 0;
         expected_taps.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_taps.size() == 0) begin
               report_mismatch($sformatf("tap x=%0d y=%0d with none predicted",
                                         rsp_data.tap_x, rsp_data.tap_y));
            end else begin
               want_tap = expected_taps.pop_front();
               if (rsp_data.tap_x !== want_tap.tap_x)
                  report_mismatch($sformatf("tap_x %0d, predicted %0d",
                                            rsp_data.tap_x, want_tap.tap_x));
               if (rsp_data.tap_y !== want_tap.tap_y)
                  report_mismatch($sformatf("tap_y %0d, predicted %0d",
                                            rsp_data.tap_y, want_tap.tap_y));
            end
         end
         if (csr_wr_en) begin
            case (ttd_pkg::csr_index_type'(csr_index))
               ttd_pkg::REG_TAP_MAX_TIME:  settings.tap_max_time  = csr_wr_data;
               ttd_pkg::REG_MOVE_LIMIT:
                  settings.move_limit = csr_wr_data[ttd_pkg::MOVE_BITS-1:0];
               ttd_pkg::REG_TAP_GAP_MIN:   settings.tap_gap_min   = csr_wr_data;
               ttd_pkg::REG_BOUNCE_WINDOW: settings.bounce_window = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            track_touch(req_data);
      end
      taps_pending = expected_taps.size();
   end

endmodule

// File: tb/touch_tap_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_detector_test
// Drives the touch tap detector with directed touch sequences and then with
// random presses, holds, drags and releases under several register settings
// and idle patterns; the checker beside the block predicts and compares taps.
// ----------------------------------------------------------------------------
module touch_tap_detector_test;

   typedef logic [ttd_pkg::COORD_BITS-1:0] coord_type;

   localparam int IDLE_LIMIT      = 3000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 8;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_valid   = 1'b0;
   logic                              req_stall;
   ttd_pkg::req_type                  req_data    = '0;
   logic                              rsp_valid;
   logic                              rsp_stall   = 1'b0;
   ttd_pkg::rsp_type                  rsp_data;
   logic                              csr_wr_en   = 1'b0;
   logic [ttd_pkg::CSR_IDX_BITS-1:0]  csr_index   = '0;
   logic [ttd_pkg::CSR_DATA_BITS-1:0] csr_wr_data = '0;

   int error_count;
   int taps_pending;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_cycles        = 0;
   int idle_cycles        = 0;
   int samples_sent       = 0;
   int saved_idle_pct;

   logic [ttd_pkg::TIME_BITS-1:0] clock_ms;
   ttd_pkg::cfg_type              settings = '{tap_max_time: ttd_pkg::TAP_MAX_TIME_RST,
                                               move_limit: ttd_pkg::MOVE_LIMIT_RST,
                                               tap_gap_min: ttd_pkg::TAP_GAP_MIN_RST,
                                               bounce_window: ttd_pkg::BOUNCE_WINDOW_RST};

   always #4 clock = ~clock;

   touch_tap_detector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   touch_tap_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .error_count  (error_count),
      .taps_pending (taps_pending)
   );

   // tap receiver: random stalls, plus one long hold-off when hold_cycles is set
   initial forever begin
      @(posedge clock);
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         repeat (hold_cycles) @(posedge clock);
         hold_cycles = 0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("touch_tap_detector_test NOT OK");
         $finish;
      end
   end

   function automatic ttd_pkg::req_type sample(input logic p, input coord_type x,
                                               input coord_type y,
                                               input logic [ttd_pkg::TIME_BITS-1:0] t);
      return '{pressed: p, pos_x: x, pos_y: y, now_time: t};
   endfunction

   // coordinate within +-spread of c, clamped to the panel
   function automatic coord_type nudge(input coord_type c, input int spread);
      int v;
      v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[ttd_pkg::COORD_BITS-1:0];
   endfunction

   task automatic send_sample(input ttd_pkg::req_type s, input bit counted);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= s;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (counted) samples_sent++;
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (taps_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input ttd_pkg::csr_index_type idx,
                            input logic [ttd_pkg::CSR_DATA_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] tap_max, input logic [15:0] move,
                                 input logic [15:0] gap_min, input logic [15:0] bounce);
      write_csr(ttd_pkg::REG_TAP_MAX_TIME, tap_max);
      write_csr(ttd_pkg::REG_MOVE_LIMIT, move);
      write_csr(ttd_pkg::REG_TAP_GAP_MIN, gap_min);
      write_csr(ttd_pkg::REG_BOUNCE_WINDOW, bounce);
      csr_wr_en <= 1'b0;
      settings = '{tap_max_time: tap_max, move_limit: move[ttd_pkg::MOVE_BITS-1:0],
                   tap_gap_min: gap_min, bounce_window: bounce};
   endtask

   // press, up to four held samples, release; timing scaled to the current settings
   task automatic tap_gesture();
      int                            gap;
      int                            dur;
      int                            n_held;
      int                            spread;
      coord_type                     x0;
      coord_type                     y0;
      logic [ttd_pkg::TIME_BITS-1:0] t_press;
      if ($urandom_range(9) < 3)
         gap = $urandom_range(0, settings.bounce_window);
      else
         gap = settings.bounce_window +
               $urandom_range(0, settings.tap_gap_min + settings.tap_max_time + 20);
      clock_ms = clock_ms + gap;
      t_press  = clock_ms;
      x0 = coord_type'($urandom);
      y0 = coord_type'($urandom);
      if ($urandom_range(9) == 0) begin
         x0 = $urandom_range(1) ? 12'hFFF : 12'h000;
         y0 = $urandom_range(1) ? 12'hFFF : 12'h000;
      end
      send_sample(sample(1'b1, x0, y0, t_press), 1'b1);
      case ($urandom_range(9))
         0:       dur = int'(settings.tap_max_time);
         1:       dur = settings.tap_max_time + 1;
         2:       dur = 0;
         default: dur = $urandom_range(0, settings.tap_max_time + settings.tap_max_time / 4 + 2);
      endcase
      n_held = $urandom_range(0, 4);
      for (int k = 1; k <= n_held; k++) begin
         if ($urandom_range(3) == 0)
            spread = int'(settings.move_limit);
         else
            spread = (settings.move_limit > 0) ? settings.move_limit - 1 : 0;
         if ($urandom_range(9) == 0)
            send_sample(sample(1'b1, coord_type'($urandom), coord_type'($urandom),
                               t_press + dur * k / (n_held + 1)), 1'b1);
         else
            send_sample(sample(1'b1, nudge(x0, spread), nudge(y0, spread),
                               t_press + dur * k / (n_held + 1)), 1'b1);
      end
      clock_ms = t_press + dur;
      if ($urandom_range(1))
         send_sample(sample(1'b0, '0, '0, clock_ms), 1'b1);
      else
         send_sample(sample(1'b0, coord_type'($urandom), coord_type'($urandom), clock_ms),
                     1'b1);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // bounce right after reset, idle release, exact limits, drag, wrap
      send_sample(sample(1'b1, 12'h123, 12'h456, 32'd10), 1'b1);
      send_sample(sample(1'b0, 12'h000, 12'h000, 32'd20), 1'b1);
      send_sample(sample(1'b1, 12'hFFF, 12'h000, 32'd1000), 1'b1);
      send_sample(sample(1'b0, 12'h000, 12'h000, 32'd1300), 1'b1);
      send_sample(sample(1'b1, 12'h007, 12'h007, 32'd1320), 1'b1);
      send_sample(sample(1'b1, 12'h000, 12'hFFF, 32'd1340), 1'b1);
      send_sample(sample(1'b0, 12'h000, 12'h000, 32'd1400), 1'b1);
      send_sample(sample(1'b1, 12'hFFF, 12'hFFF, 32'd1500), 1'b1);
      send_sample(sample(1'b1, 12'hFF6, 12'hFFF, 32'd1520), 1'b1);
      send_sample(sample(1'b1, 12'hFFF, 12'hFF5, 32'd1540), 1'b1);
      send_sample(sample(1'b0, 12'h000, 12'h000, 32'd1600), 1'b1);
      send_sample(sample(1'b1, 12'd1234, 12'd2345, 32'd2000), 1'b1);
      send_sample(sample(1'b0, 12'h000, 12'h000, 32'd2301), 1'b1);
      send_sample(sample(1'b1, 12'h000, 12'h000, 32'd3000), 1'b1);
      send_sample(sample(1'b0, 12'hFFF, 12'hFFF, 32'd3150), 1'b1);
      send_sample(sample(1'b1, 12'hAAA, 12'h555, 32'hFFFF_FF00), 1'b1);
      send_sample(sample(1'b1, 12'hAAB, 12'h554, 32'hFFFF_FF80), 1'b1);
      send_sample(sample(1'b0, 12'h000, 12'h000, 32'h0000_0020), 1'b1);
      send_sample(sample(1'b0, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF), 1'b1);
      clock_ms = 32'h0000_0020;

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            quiesce();
            case (phase)
               1: apply_settings(16'd300, 16'd10, 16'd150, 16'd40);
               2: apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
               3: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
               5: apply_settings(16'd1, 16'd1, 16'd1, 16'd1);
               default: apply_settings(16'($urandom_range(0, 1000)),
                                       16'($urandom_range(0, 40) |
                                          ($urandom_range(1) ? ($urandom & 32'hF000)
                                                             : 32'h0)),
                                       16'($urandom_range(0, 600)),
                                       16'($urandom_range(0, 200)));
            endcase
            if ($urandom_range(4) == 0)
               clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 100000);
         end
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         endcase
         if (phase == 1) begin
            // receiver holds off while taps keep coming, so the input backs up
            saved_idle_pct  = sender_idle_pct;
            sender_idle_pct = 0;
            hold_cycles     = HOLD_OFF_CYCLES;
            repeat (12) tap_gesture();
            sender_idle_pct = saved_idle_pct;
         end
         while (samples_sent < (phase + 1) * ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 12) begin
               if ($urandom_range(1))
                  send_sample(sample(1'($urandom_range(1)), coord_type'($urandom),
                                     coord_type'($urandom), $urandom), 1'b0);
               else
                  send_sample(sample(1'($urandom_range(1)), coord_type'($urandom),
                                     coord_type'($urandom),
                                     clock_ms + $urandom_range(0, 500)), 1'b0);
            end else begin
               tap_gesture();
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (taps_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("touch_tap_detector_test OK");
      else
         $display("touch_tap_detector_test NOT OK");
      $finish;
   end

endmodule

// File: touch_tap_detector.f
hdl/ttd_pkg.sv
hdl/ttd_cfg_regs.sv
hdl/ttd_in_reg.sv
hdl/ttd_tap_logic.sv
hdl/touch_tap_detector.sv
hdl/ttd_checker.sv
tb/touch_tap_checker.sv
tb/touch_tap_detector_test.sv
